// File: hw/rtl/barometric_pressure_compensation_assert.svh
// assertion macros for the barometric pressure compensation block
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bpc_pkg.sv
// shared widths, register codes, constants and helpers for the compensation block
package bpc_pkg;

  localparam int RawTempW = 16;
  localparam int RawPresW = 19;
  localparam int TempW    = 16;
  localparam int PresW    = 18;
  localparam int CalW     = 64;
  localparam int CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAL0 = 2'd0,
    REG_CAL1 = 2'd1,
    REG_CAL2 = 2'd2,
    REG_OSS  = 2'd3
  } bpc_reg_t;

  localparam logic [31:0] B6_OFS   = 32'd4000;
  localparam logic [31:0] B4_OFS   = 32'd32768;
  localparam logic [31:0] B7_SCALE = 32'd50000;
  localparam logic [31:0] P_K1     = 32'd3038;
  localparam logic [31:0] P_K2     = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_K3     = 32'd3791;
  localparam logic [1:0]  OSS_RST  = 2'd3;

  function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return 32'($signed(v));
  endfunction

endpackage

// File: hw/rtl/bpc_if.sv
// valid/ready channel interfaces for sample words and result words
interface bpc_in_if;
  import bpc_pkg::*;
  logic                valid;
  logic                ready;
  logic [RawTempW-1:0] raw_temperature;
  logic [RawPresW-1:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temperature_tenths;
  logic [PresW-1:0]        pressure_pa;
  logic                    calc_error;
  modport source (output valid, temperature_tenths, pressure_pa, calc_error, input ready);
  modport sink   (input valid, temperature_tenths, pressure_pa, calc_error, output ready);
endinterface

// File: hw/rtl/bpc_udiv.sv
// pipelined restoring unsigned divider, one quotient bit per stage
module bpc_udiv #(
  parameter int NumW = 32,
  parameter int DenW = 32,
  parameter int TagW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  input  logic [TagW-1:0] tag,
  output logic            out_vld,
  output logic [NumW-1:0] quo,
  output logic [TagW-1:0] out_tag
);

  logic            vld_r [NumW];
  logic [NumW-1:0] num_r [NumW];   // remaining dividend bits, quotient shifts in
  logic [DenW-1:0] rem_r [NumW];
  logic [DenW-1:0] den_r [NumW];
  logic [TagW-1:0] tag_r [NumW];

  for (genvar i = 0; i < NumW; i++) begin : g_st
    logic            vld_in;
    logic [NumW-1:0] num_in;
    logic [DenW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [TagW-1:0] tag_in;
    logic [DenW:0]   rem_sh;
    logic [DenW:0]   diff;
    logic            ge;

    if (i == 0) begin : g_first
      assign vld_in = in_vld;
      assign num_in = num;
      assign rem_in = '0;
      assign den_in = den;
      assign tag_in = tag;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign num_in = num_r[i-1];
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign tag_in = tag_r[i-1];
    end

    assign rem_sh = {rem_in, num_in[NumW-1]};
    assign diff   = rem_sh - {1'b0, den_in};
    assign ge     = ~diff[DenW];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[i] <= {num_in[NumW-2:0], ge};
        rem_r[i] <= ge ? diff[DenW-1:0] : rem_sh[DenW-1:0];
        den_r[i] <= den_in;
        tag_r[i] <= tag_in;
      end
    end
  end

  assign out_vld = vld_r[NumW-1];
  assign quo     = num_r[NumW-1];
  assign out_tag = tag_r[NumW-1];

endmodule

// File: hw/rtl/barometric_pressure_compensation.sv
// top level: pipelined integer temperature and pressure compensation
// One sample word (raw temperature, pressure already aligned to the oversampling
// setting) enters per cycle and one result word leaves per cycle when not stalled,
// via two bit-serial divider pipelines (27 stages for the temperature quotient,
// 32 for the pressure quotient) and 12 arithmetic stages that each hold at most
// one 32x32 multiply per path or a short add chain. All stages advance together
// and hold while the output word waits, so nothing is lost on a stall. Calibration
// words and oversampling are to be written through cfg_* only while the block is
// idle (not enforced by the block); a zero divisor flags calc_error and zeroes
// both results, temperature is in tenths of a degree and pressure saturates to 0..262143 Pa.
`include "barometric_pressure_compensation_assert.svh"

module barometric_pressure_compensation (
  input  logic                         clk,
  input  logic                         rst_n,
  bpc_in_if.sink                       in_ch,
  bpc_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [bpc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bpc_pkg::CalW-1:0]     cfg_wdata
);
  import bpc_pkg::*;

  localparam int Q1W  = 27;            // |mc << 11| fits in 27 bits
  localparam int T1W  = 32 + RawPresW + 2;
  localparam int T2W  = 32 + 2;

  // configuration registers
  logic [63:0] cal0_r, cal1_r;
  logic [31:0] cal2_r;
  logic [1:0]  oss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal0_r <= '0;
      cal1_r <= '0;
      cal2_r <= '0;
      oss_r  <= OSS_RST;
    end else if (cfg_we) begin
      unique case (bpc_reg_t'(cfg_index))
        REG_CAL0: cal0_r <= cfg_wdata;
        REG_CAL1: cal1_r <= cfg_wdata;
        REG_CAL2: cal2_r <= cfg_wdata[31:0];
        REG_OSS:  oss_r  <= cfg_wdata[1:0];
        default:  ;
      endcase
    end
  end

  // unpacked coefficients
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(cal0_r[15:0]);
  assign ac2 = sx16(cal0_r[31:16]);
  assign ac3 = sx16(cal0_r[47:32]);
  assign ac4 = {16'd0, cal0_r[63:48]};
  assign ac5 = {16'd0, cal1_r[15:0]};
  assign ac6 = {16'd0, cal1_r[31:16]};
  assign b1  = sx16(cal1_r[47:32]);
  assign b2  = sx16(cal1_r[63:48]);
  assign mc  = sx16(cal2_r[15:0]);
  assign md  = sx16(cal2_r[31:16]);

  // whole pipe moves when the output word is empty or being taken
  logic adv;
  logic out_vld_r;
  assign adv         = ~out_vld_r | out_ch.ready;
  assign in_ch.ready = adv;

  // valid bits
  logic s1_vld_r, s2_vld_r, s4_vld_r, s5_vld_r, s6_vld_r, s7_vld_r, s8_vld_r, s9_vld_r;
  logic s10_vld_r, s11_vld_r, s12_vld_r;
  logic d1_vld, d2_vld;

  // stage 1: (ut - ac6) * ac5
  logic [31:0]         s1_prod_r;
  logic [RawPresW-1:0] s1_up_r;
  // stage 2: x1 and temperature divisor
  logic [31:0]         s2_x1_r, s2_den_r;
  logic [RawPresW-1:0] s2_up_r;
  // stage 4: b5, b6
  logic [31:0]         s4_b5_r, s4_b6_r;
  logic [RawPresW-1:0] s4_up_r;
  logic                s4_err_r;
  // stage 5: products on b6
  logic [31:0]         s5_sq_r, s5_mac2_r, s5_mac3_r, s5_b5_r;
  logic [RawPresW-1:0] s5_up_r;
  logic                s5_err_r;
  // stage 6: products on b6sq
  logic [31:0]         s6_mb2_r, s6_mb1_r, s6_mac2_r, s6_mac3_r, s6_b5_r;
  logic [RawPresW-1:0] s6_up_r;
  logic                s6_err_r;
  // stage 7: x3 for b3, x3 for b4
  logic [31:0]         s7_x3_r, s7_y3_r, s7_b5_r;
  logic [RawPresW-1:0] s7_up_r;
  logic                s7_err_r;
  // stage 8: b3 and ac4 product
  logic [31:0]         s8_b3_r, s8_mac4_r, s8_b5_r;
  logic [RawPresW-1:0] s8_up_r;
  logic                s8_err_r;
  // stage 9: b4 and b7
  logic [31:0]         s9_b4_r, s9_b7_r, s9_b5_r;
  logic                s9_err_r;
  // stages 10-12: pressure polish
  logic [31:0]         s10_p_r, s10_sq_r, s10_mk2_r, s10_b5_r;
  logic                s10_err_r;
  logic [31:0]         s11_p_r, s11_mk1_r, s11_x2_r, s11_b5_r;
  logic                s11_err_r;
  logic [31:0]         s12_pres_r, s12_t_r;
  logic                s12_err_r;
  // output word
  logic [TempW-1:0]    out_temp_r;
  logic [PresW-1:0]    out_pres_r;
  logic                out_err_r;

  // stage 1 and 2 datapath
  logic [31:0] s1_diff;
  assign s1_diff = {16'd0, in_ch.raw_temperature} - ac6;

  // divider 1 setup: (mc << 11) / den, signed truncating via magnitudes
  logic [31:0]    mc_sh, mc_mag, den_mag;
  logic           d1_qneg, d1_err;
  logic [T1W-1:0] d1_tag_in, d1_tag;
  logic [Q1W-1:0] d1_quo;
  assign mc_sh     = mc << 11;
  assign mc_mag    = mc_sh[31] ? -mc_sh : mc_sh;
  assign den_mag   = s2_den_r[31] ? -s2_den_r : s2_den_r;
  assign d1_qneg   = mc_sh[31] ^ s2_den_r[31];
  assign d1_err    = (s2_den_r == '0);
  assign d1_tag_in = {s2_x1_r, s2_up_r, d1_qneg, d1_err};

  bpc_udiv #(.NumW(Q1W), .DenW(32), .TagW(T1W)) u_tdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (s2_vld_r),
    .num     (mc_mag[Q1W-1:0]),
    .den     (den_mag),
    .tag     (d1_tag_in),
    .out_vld (d1_vld),
    .quo     (d1_quo),
    .out_tag (d1_tag)
  );

  // stage 4 datapath: b5 = x1 + x2, b6 = b5 - 4000
  logic [31:0]         d1_x1, d1_q32, s4_x2, s4_b5;
  logic [RawPresW-1:0] d1_up;
  assign d1_x1  = d1_tag[T1W-1 -: 32];
  assign d1_up  = d1_tag[RawPresW+1:2];
  assign d1_q32 = {{(32-Q1W){1'b0}}, d1_quo};
  assign s4_x2  = d1_tag[1] ? -d1_q32 : d1_q32;
  assign s4_b5  = d1_x1 + s4_x2;

  // stage 6-9 datapath
  logic [31:0] s6_b6sq, s8_b3pre, s8_b3sh, s9_b4, s9_scale;
  assign s6_b6sq  = sra32(s5_sq_r, 12);
  assign s8_b3pre = (ac1 << 2) + s7_x3_r;
  assign s8_b3sh  = s8_b3pre << oss_r;
  assign s9_b4    = s8_mac4_r >> 15;
  assign s9_scale = B7_SCALE >> oss_r;

  // divider 2 setup: b7 / b4 with the doubling placed by b7's top bit
  logic           d2_hi;
  logic [31:0]    d2_num, d2_quo, s10_p, s10_s;
  logic [T2W-1:0] d2_tag_in, d2_tag;
  assign d2_hi     = s9_b7_r[31];
  assign d2_num    = d2_hi ? s9_b7_r : (s9_b7_r << 1);
  assign d2_tag_in = {s9_b5_r, s9_err_r | (s9_b4_r == '0), d2_hi};

  bpc_udiv #(.NumW(32), .DenW(32), .TagW(T2W)) u_pdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (s9_vld_r),
    .num     (d2_num),
    .den     (s9_b4_r),
    .tag     (d2_tag_in),
    .out_vld (d2_vld),
    .quo     (d2_quo),
    .out_tag (d2_tag)
  );

  assign s10_p = d2_tag[0] ? (d2_quo << 1) : d2_quo;
  assign s10_s = sra32(s10_p, 8);

  // stage 12 datapath
  logic [31:0] s12_sum;
  assign s12_sum = sra32(s11_mk1_r, 16) + s11_x2_r + P_K3;

  // output saturation
  logic [TempW-1:0] out_temp_nxt;
  logic [PresW-1:0] out_pres_nxt;
  always_comb begin
    if ($signed(s12_t_r) > 32'sd32767) begin
      out_temp_nxt = 16'h7FFF;
    end else if ($signed(s12_t_r) < -32'sd32768) begin
      out_temp_nxt = 16'h8000;
    end else begin
      out_temp_nxt = s12_t_r[TempW-1:0];
    end
    if (s12_pres_r[31]) begin
      out_pres_nxt = '0;
    end else if (s12_pres_r > 32'd262143) begin
      out_pres_nxt = '1;
    end else begin
      out_pres_nxt = s12_pres_r[PresW-1:0];
    end
    if (s12_err_r) begin
      out_temp_nxt = '0;
      out_pres_nxt = '0;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      s9_vld_r  <= 1'b0;
      s10_vld_r <= 1'b0;
      s11_vld_r <= 1'b0;
      s12_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_ch.valid;
      s2_vld_r  <= s1_vld_r;
      s4_vld_r  <= d1_vld;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= s7_vld_r;
      s9_vld_r  <= s8_vld_r;
      s10_vld_r <= d2_vld;
      s11_vld_r <= s10_vld_r;
      s12_vld_r <= s11_vld_r;
      out_vld_r <= s12_vld_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_r  <= s1_diff * ac5;
      s1_up_r    <= in_ch.raw_pressure;

      s2_x1_r    <= sra32(s1_prod_r, 15);
      s2_den_r   <= sra32(s1_prod_r, 15) + md;
      s2_up_r    <= s1_up_r;

      s4_b5_r    <= s4_b5;
      s4_b6_r    <= s4_b5 - B6_OFS;
      s4_up_r    <= d1_up;
      s4_err_r   <= d1_tag[0];

      s5_sq_r    <= s4_b6_r * s4_b6_r;
      s5_mac2_r  <= ac2 * s4_b6_r;
      s5_mac3_r  <= ac3 * s4_b6_r;
      s5_b5_r    <= s4_b5_r;
      s5_up_r    <= s4_up_r;
      s5_err_r   <= s4_err_r;

      s6_mb2_r   <= b2 * s6_b6sq;
      s6_mb1_r   <= b1 * s6_b6sq;
      s6_mac2_r  <= s5_mac2_r;
      s6_mac3_r  <= s5_mac3_r;
      s6_b5_r    <= s5_b5_r;
      s6_up_r    <= s5_up_r;
      s6_err_r   <= s5_err_r;

      s7_x3_r    <= sra32(s6_mb2_r, 11) + sra32(s6_mac2_r, 11);
      s7_y3_r    <= sra32(sra32(s6_mac3_r, 13) + sra32(s6_mb1_r, 16) + 32'd2, 2);
      s7_b5_r    <= s6_b5_r;
      s7_up_r    <= s6_up_r;
      s7_err_r   <= s6_err_r;

      s8_b3_r    <= sra32(s8_b3sh + 32'd2, 2);
      s8_mac4_r  <= ac4 * (s7_y3_r + B4_OFS);
      s8_b5_r    <= s7_b5_r;
      s8_up_r    <= s7_up_r;
      s8_err_r   <= s7_err_r;

      s9_b4_r    <= s9_b4;
      s9_b7_r    <= ({{(32-RawPresW){1'b0}}, s8_up_r} - s8_b3_r) * s9_scale;
      s9_b5_r    <= s8_b5_r;
      s9_err_r   <= s8_err_r;

      s10_p_r    <= s10_p;
      s10_sq_r   <= s10_s * s10_s;
      s10_mk2_r  <= P_K2 * s10_p;
      s10_b5_r   <= d2_tag[T2W-1 -: 32];
      s10_err_r  <= d2_tag[1];

      s11_p_r    <= s10_p_r;
      s11_mk1_r  <= s10_sq_r * P_K1;
      s11_x2_r   <= sra32(s10_mk2_r, 16);
      s11_b5_r   <= s10_b5_r;
      s11_err_r  <= s10_err_r;

      s12_pres_r <= s11_p_r + sra32(s12_sum, 4);
      s12_t_r    <= sra32(s11_b5_r + 32'd8, 4);
      s12_err_r  <= s11_err_r;

      out_temp_r <= out_temp_nxt;
      out_pres_r <= out_pres_nxt;
      out_err_r  <= s12_err_r;
    end
  end

  assign out_ch.valid              = out_vld_r;
  assign out_ch.temperature_tenths = out_temp_r;
  assign out_ch.pressure_pa        = out_pres_r;
  assign out_ch.calc_error         = out_err_r;

  // a flagged word carries zero results
  `BPC_ASSERT_IMP(a_err_zero, out_vld_r && out_err_r, out_temp_r == '0 && out_pres_r == '0, "error word not zeroed")
  // oversampling write lands on the next edge
  `BPC_ASSERT_NXT(a_oss_wr, cfg_we && cfg_index == REG_OSS, oss_r == $past(cfg_wdata[1:0]), "oversampling write lost")
  // a word held at the output keeps the whole pipe frozen
  `BPC_ASSERT_NXT(a_hold, out_vld_r && !out_ch.ready, $stable(s12_t_r) && $stable(s12_err_r), "pipe moved under stall")

endmodule

// File: test/bpc_checker.sv
// predictor and scoreboard for the pressure compensation block
`timescale 1ns / 100ps

module bpc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  bpc_in_if                           in_ch,
  bpc_out_if                          out_ch,
  input  logic                        cfg_we,
  input  logic [bpc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bpc_pkg::CalW-1:0]    cfg_wdata,
  input  logic                        end_of_test,
  output int                          pending,
  output int                          fail_count,
  output int                          result_count,
  output int                          error_count
);
  import bpc_pkg::*;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [PresW-1:0]        pres;
    logic                    err;
  } reading_t;

  logic [63:0] cal0, cal1;
  logic [31:0] cal2;
  logic [1:0]  oss;
  reading_t    expected_q[$];
  logic        end_seen;

  function automatic logic [31:0] floor_shift(input logic [31:0] v, input int s);
    return v[31] ? ~((~v) >> s) : v >> s;
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic reading_t compensate(input logic [15:0] raw_t, input logic [18:0] raw_p);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
    logic [31:0] x1, x2, x3, den, b3, b4, b5, b6, b6sq, b7, p, pres;
    longint      q, t, ps;
    reading_t    r;
    ac1 = ext16(cal0[15:0]);   ac2 = ext16(cal0[31:16]);
    ac3 = ext16(cal0[47:32]);  ac4 = {16'd0, cal0[63:48]};
    ac5 = {16'd0, cal1[15:0]}; ac6 = {16'd0, cal1[31:16]};
    b1  = ext16(cal1[47:32]);  b2  = ext16(cal1[63:48]);
    mc  = ext16(cal2[15:0]);   md  = ext16(cal2[31:16]);
    ut  = {16'd0, raw_t};      up  = {13'd0, raw_p};
    r = '{temp: '0, pres: '0, err: 1'b1};
    // temperature
    x1  = floor_shift((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    q   = longint'($signed(mc << 11)) / longint'($signed(den));
    x2  = q[31:0];
    b5  = x1 + x2;
    // pressure
    b6   = b5 - B6_OFS;
    b6sq = floor_shift(b6 * b6, 12);
    x1   = floor_shift(b2 * b6sq, 11);
    x2   = floor_shift(ac2 * b6, 11);
    x3   = x1 + x2;
    b3   = floor_shift(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
    x1   = floor_shift(ac3 * b6, 13);
    x2   = floor_shift(b1 * b6sq, 16);
    x3   = floor_shift(x1 + x2 + 32'd2, 2);
    b4   = (ac4 * (x3 + B4_OFS)) >> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * (B7_SCALE >> oss);
    p  = (b7 < 32'h8000_0000) ? (b7 * 32'd2) / b4 : (b7 / b4) * 32'd2;
    x1 = floor_shift(p, 8) * floor_shift(p, 8);
    x1 = floor_shift(x1 * P_K1, 16);
    x2 = floor_shift(P_K2 * p, 16);
    pres = p + floor_shift(x1 + x2 + P_K3, 4);
    t  = longint'($signed(floor_shift(b5 + 32'd8, 4)));
    ps = longint'($signed(pres));
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (ps < 0) ps = 0;
    if (ps > 262143) ps = 262143;
    r.temp = t[15:0];
    r.pres = ps[17:0];
    r.err  = 1'b0;
    return r;
  endfunction

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    reading_t got, want;
    if (!rst_n) begin
      cal0 <= '0; cal1 <= '0; cal2 <= '0; oss <= OSS_RST;
      expected_q.delete();
      pending <= 0;
      fail_count <= 0;
      result_count <= 0;
      error_count <= 0;
      end_seen <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (bpc_reg_t'(cfg_index))
          REG_CAL0: cal0 <= cfg_wdata;
          REG_CAL1: cal1 <= cfg_wdata;
          REG_CAL2: cal2 <= cfg_wdata[31:0];
          REG_OSS:  oss  <= cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(compensate(in_ch.raw_temperature, in_ch.raw_pressure));
      if (out_ch.valid && out_ch.ready) begin
        got = '{temp: out_ch.temperature_tenths, pres: out_ch.pressure_pa,
                err: out_ch.calc_error};
        result_count <= result_count + 1;
        if (got.err) error_count <= error_count + 1;
        if (expected_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (got.temp !== want.temp)
            report($sformatf("temperature_tenths %0d, expected %0d", got.temp, want.temp));
          if (got.pres !== want.pres)
            report($sformatf("pressure_pa %0d, expected %0d", got.pres, want.pres));
          if (got.err !== want.err)
            report($sformatf("calc_error %0b, expected %0b", got.err, want.err));
        end
      end
      pending <= expected_q.size();
      if (end_of_test && !end_seen) begin
        end_seen <= 1'b1;
        if (expected_q.size() != 0)
          report($sformatf("%0d result words never arrived", expected_q.size()));
      end
    end
  end
endmodule

// File: test/testbench.sv
// stimulus and verdict for the barometric pressure compensation block
`timescale 1ns / 100ps

module testbench;
  import bpc_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CalW-1:0]     cfg_wdata;
  logic                end_of_test;
  int                  pending, fail_count, result_count, error_count;
  int                  burst_left;
  int                  items_sent;
  int                  phases;

  bpc_in_if  in_ch ();
  bpc_out_if out_ch ();

  barometric_pressure_compensation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bpc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .end_of_test  (end_of_test),
    .pending      (pending),
    .fail_count   (fail_count),
    .result_count (result_count),
    .error_count  (error_count)
  );

  // datasheet example calibration, a known-good starting point
  localparam logic [15:0] AC1 = 16'd408,   AC2 = 16'hFFB8;  // -72
  localparam logic [15:0] AC3 = 16'hC7D1,  AC4 = 16'd32741; // ac3 = -14383
  localparam logic [15:0] AC5 = 16'd32757, AC6 = 16'd23153;
  localparam logic [15:0] B1  = 16'd6190,  B2  = 16'd4;
  localparam logic [15:0] MC  = 16'hDDF9,  MD  = 16'd2868;  // mc = -8711

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("timeout with %0d words still expected", pending);
    $display("testbench failed");
    $finish;
  end

  // result side: stall pattern switches at random among three styles
  initial begin
    int style, stall;
    out_ch.ready <= 1'b0;
    stall = 0;
    forever begin
      style = $urandom_range(0, 2);
      repeat ($urandom_range(50, 250)) begin
        @(posedge clk);
        case (style)
          0: out_ch.ready <= 1'b1;                          // no back-pressure
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);   // coin flip
          default: begin                                    // long stalls now and then
            if (stall == 0 && $urandom_range(0, 15) == 0) stall = $urandom_range(1, 20);
            out_ch.ready <= (stall == 0);
            if (stall != 0) stall--;
          end
        endcase
      end
    end
  end

  // all four registers in one run of writes, write enable held across them
  task automatic program_cal(input logic [63:0] c0, input logic [63:0] c1,
                             input logic [31:0] c2, input logic [1:0] o);
    cfg_we <= 1'b1; cfg_index <= REG_CAL0; cfg_wdata <= c0;
    @(posedge clk);
    cfg_index <= REG_CAL1; cfg_wdata <= c1;
    @(posedge clk);
    cfg_index <= REG_CAL2; cfg_wdata <= {32'd0, c2};
    @(posedge clk);
    cfg_index <= REG_OSS; cfg_wdata <= {62'd0, o};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // block must be empty before touching the registers
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // one sample word; valid stays high inside a burst, drops for random gaps between
  task automatic send_word(input logic [15:0] ut, input logic [18:0] up);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_temperature <= ut;
    in_ch.raw_pressure <= up;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  function automatic logic [15:0] jitter(input logic [15:0] v, input int span);
    return v + 16'($urandom_range(0, 2 * span)) - 16'(span);
  endfunction

  // random phase: mostly plausible calibration, sometimes anything at all
  task automatic random_phase(input int n, input logic [1:0] o);
    logic [63:0] c0, c1;
    logic [31:0] c2;
    logic [18:0] up;
    if ($urandom_range(0, 9) < 7) begin
      c0 = {jitter(AC4, 2000), jitter(AC3, 3000), jitter(AC2, 500), jitter(AC1, 3000)};
      c1 = {jitter(B2, 100), jitter(B1, 1000), jitter(AC6, 4000), jitter(AC5, 4000)};
      c2 = {jitter(MD, 800), jitter(MC, 2000)};
    end else begin
      c0 = {$urandom, $urandom};
      c1 = {$urandom, $urandom};
      c2 = $urandom;
    end
    program_cal(c0, c1, c2, o);
    phases++;
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) begin
        // near-real readings scaled to the oversampling setting
        up = 19'($urandom_range(15000, 45000)) << o;
        send_word(16'($urandom_range(18000, 36000)), up);
      end else begin
        send_word(16'($urandom), 19'($urandom));
      end
    end
    stop_sending();
    drain();
  endtask

  initial begin
    logic [63:0] ds0, ds1;
    logic [31:0] ds2;
    rst_n <= 1'b0;
    cfg_we <= 1'b0; cfg_index <= REG_CAL0; cfg_wdata <= '0;
    in_ch.valid <= 1'b0; in_ch.raw_temperature <= '0; in_ch.raw_pressure <= '0;
    end_of_test <= 1'b0;
    burst_left = 0; items_sent = 0; phases = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: md and ac5 are zero, so every word hits the temperature divisor
    send_word(16'd27898, 19'd23843);
    send_word(16'hFFFF, 19'h7FFFF);
    stop_sending();
    drain();

    // datasheet calibration at oss 0, plus field extremes
    ds0 = {AC4, AC3, AC2, AC1};
    ds1 = {B2, B1, AC6, AC5};
    ds2 = {MD, MC};
    program_cal(ds0, ds1, ds2, 2'd0);
    send_word(16'd27898, 19'd23843);
    send_word(16'd0, 19'd0);
    send_word(16'hFFFF, 19'h7FFFF);
    send_word(16'd0, 19'h7FFFF);
    send_word(16'hFFFF, 19'd0);
    send_word(16'h5555, 19'h2AAAA);
    send_word(16'hAAAA, 19'h55555);
    stop_sending();
    drain();

    // md zero and ut equal to ac6 makes the temperature divisor zero
    program_cal(ds0, ds1, {16'd0, MC}, 2'd3);
    send_word(AC6, 19'd100000);
    send_word(AC6 + 16'd1, 19'd100000);
    send_word(16'd27898, 19'd190744);
    stop_sending();
    drain();

    // ac4 zero forces b4 to zero, the pressure divisor
    program_cal({16'd0, AC3, AC2, AC1}, ds1, ds2, 2'd2);
    send_word(16'd27898, 19'd95372);
    send_word(16'd30000, 19'd0);
    stop_sending();
    drain();

    // all-ones calibration at the top oversampling, wide intermediates wrap
    program_cal('1, '1, '1, 2'd3);
    send_word(16'd0, 19'd0);
    send_word(16'hFFFF, 19'h7FFFF);
    send_word(16'd27898, 19'd23843);
    stop_sending();
    drain();

    // pressure coefficients zero apart from ac1, with a live temperature path
    program_cal({48'd0, AC1}, {32'd0, AC6, AC5}, ds2, 2'd1);
    send_word(16'd27898, 19'd47686);
    send_word(16'hFFFF, 19'h7FFFF);
    stop_sending();
    drain();
    phases += 6;

    // random part, oversampling cycles through every setting
    for (int k = 0; k < 10; k++)
      random_phase(100, 2'(k));
    random_phase(30, 2'd3);

    end_of_test <= 1'b1;
    repeat (3) @(posedge clk);
    $display("%0d sample words in %0d calibration phases, all oversampling settings",
             items_sent, phases);
    $display("%0d result words checked, %0d with calc_error set", result_count, error_count);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

// File: barometric_pressure_compensation.f
+incdir+hw/rtl
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_if.sv
hw/rtl/bpc_udiv.sv
hw/rtl/barometric_pressure_compensation.sv
test/bpc_checker.sv
test/testbench.sv
